### design/rvce_pkg.sv
// Shared types, codes and a helper function for the RV64C execute block.
package rvce_pkg;

   localparam int XLEN        = 64;
   localparam int REG_COUNT   = 32;
   localparam int REG_IDX_W   = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] QUAD_0 = 2'b00;
   localparam logic [1:0] QUAD_1 = 2'b01;
   localparam logic [1:0] QUAD_2 = 2'b10;

   localparam logic [REG_IDX_W-1:0] REG_ZERO = 5'd0;
   localparam logic [REG_IDX_W-1:0] REG_RA   = 5'd1;
   localparam logic [REG_IDX_W-1:0] REG_SP   = 5'd2;

   localparam logic [2:0] EXC_NONE        = 3'd0;
   localparam logic [2:0] EXC_ILLEGAL     = 3'd1;
   localparam logic [2:0] EXC_BREAKPOINT  = 3'd2;
   localparam logic [2:0] EXC_LOAD_FAULT  = 3'd3;
   localparam logic [2:0] EXC_STORE_FAULT = 3'd4;

   typedef enum logic [4:0] {
      OP_ADD, OP_ADDW, OP_SUB, OP_SUBW, OP_XOR, OP_OR, OP_AND,
      OP_SRL, OP_SRA, OP_SLL, OP_LOAD, OP_STORE, OP_JUMP, OP_BEQZ,
      OP_BNEZ, OP_JR, OP_JALR, OP_ILL, OP_BRK, OP_RESP
   } uop_code_type;

   typedef struct packed {
      logic             op;
      logic [15:0]      instr_bits;
      logic [XLEN-1:0]  current_pc;
      logic [XLEN-1:0]  resp_data;
      logic             resp_fault;
   } req_type;

   typedef struct packed {
      logic [XLEN-1:0]      next_pc;
      logic                 mem_valid;
      logic                 mem_write;
      logic                 mem_wide;
      logic [XLEN-1:0]      mem_addr;
      logic [XLEN-1:0]      store_data;
      logic                 wb_valid;
      logic [REG_IDX_W-1:0] wb_index;
      logic [XLEN-1:0]      wb_value;
      logic [2:0]           exception;
   } rsp_type;

   // Classified item as it travels from the front to the back.
   typedef struct packed {
      uop_code_type         code;
      logic [REG_IDX_W-1:0] rs1;
      logic [REG_IDX_W-1:0] rs2;
      logic [REG_IDX_W-1:0] rd;
      logic                 use_rs2;
      logic                 wide;
      logic [XLEN-1:0]      imm;
      logic [XLEN-1:0]      pc;
      logic [XLEN-1:0]      resp_data;
      logic                 resp_fault;
   } uop_type;

   function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
      return {{(XLEN-32){v[31]}}, v[31:0]};
   endfunction

endpackage

### design/rvce_req_if.sv
// Valid/ready channel that carries instruction and memory response items.
interface rvce_req_if import rvce_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/rvce_rsp_if.sv
// Valid/ready channel that carries result items.
interface rvce_rsp_if import rvce_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/rvce_ram.sv
// Generic memory with one write port and one registered read port.
module rvce_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### design/rvce_front.sv
// Front end: accepts items and classifies each halfword into a micro-op.
module rvce_front import rvce_pkg::*; (
   rvce_req_if.sink req_bus,
   input  logic     q_ready,
   output logic     push,
   output uop_type  push_uop
);
   logic [15:0]          ins;
   logic [1:0]           quad;
   logic [2:0]           f3;
   logic                 b12;
   logic [REG_IDX_W-1:0] rdf, rs2f, rdp, rs2p;
   logic [5:0]           sh;
   logic [XLEN-1:0]      imm6;
   logic [6:0]           offw;
   logic [7:0]           offd;
   logic [9:0]           t4spn, t16sp;
   logic [11:0]          tj;
   logic [8:0]           tb;
   logic [7:0]           tlwsp, tswsp;
   logic [8:0]           tldsp, tsdsp;

   assign req_bus.ready = q_ready;
   assign push          = req_bus.valid && q_ready;

   assign ins   = req_bus.data.instr_bits;
   assign quad  = ins[1:0];
   assign f3    = ins[15:13];
   assign b12   = ins[12];
   assign rdf   = ins[11:7];
   assign rs2f  = ins[6:2];
   assign rdp   = {2'b01, ins[9:7]};
   assign rs2p  = {2'b01, ins[4:2]};
   assign sh    = {b12, rs2f};
   assign imm6  = {{(XLEN-6){sh[5]}}, sh};
   assign offw  = {ins[5], ins[12:10], ins[6], 2'b00};
   assign offd  = {ins[6:5], ins[12:10], 3'b000};
   assign t4spn = {ins[10:7], ins[12:11], ins[5], ins[6], 2'b00};
   assign t16sp = {b12, ins[4:3], ins[5], ins[2], ins[6], 4'b0000};
   assign tj    = {b12, ins[8], ins[10:9], ins[6], ins[7], ins[2], ins[11], ins[5:3], 1'b0};
   assign tb    = {b12, ins[6:5], ins[2], ins[11:10], ins[4:3], 1'b0};
   assign tlwsp = {ins[3:2], b12, ins[6:4], 2'b00};
   assign tldsp = {ins[4:2], b12, ins[6:5], 3'b000};
   assign tswsp = {ins[8:7], ins[12:9], 2'b00};
   assign tsdsp = {ins[9:7], ins[12:10], 3'b000};

   always_comb begin
      push_uop            = '0;
      push_uop.code       = OP_ILL;
      push_uop.pc         = req_bus.data.current_pc;
      push_uop.resp_data  = req_bus.data.resp_data;
      push_uop.resp_fault = req_bus.data.resp_fault;
      if (req_bus.data.op) begin
         push_uop.code = OP_RESP;
      end else begin
         case (quad)
            QUAD_0: begin
               push_uop.rs1 = rdp;
               push_uop.rs2 = rs2p;
               push_uop.rd  = rs2p;
               case (f3)
                  3'd0: begin
                     if (t4spn != '0) begin
                        push_uop.code = OP_ADD;
                        push_uop.rs1  = REG_SP;
                        push_uop.imm  = {{(XLEN-10){1'b0}}, t4spn};
                     end
                  end
                  3'd2: begin
                     push_uop.code = OP_LOAD;
                     push_uop.imm  = {{(XLEN-7){1'b0}}, offw};
                  end
                  3'd3: begin
                     push_uop.code = OP_LOAD;
                     push_uop.wide = 1'b1;
                     push_uop.imm  = {{(XLEN-8){1'b0}}, offd};
                  end
                  3'd6: begin
                     push_uop.code = OP_STORE;
                     push_uop.rd   = REG_ZERO;
                     push_uop.imm  = {{(XLEN-7){1'b0}}, offw};
                  end
                  3'd7: begin
                     push_uop.code = OP_STORE;
                     push_uop.rd   = REG_ZERO;
                     push_uop.wide = 1'b1;
                     push_uop.imm  = {{(XLEN-8){1'b0}}, offd};
                  end
                  default: push_uop.code = OP_ILL;
               endcase
            end
            QUAD_1: begin
               push_uop.rs1 = rdf;
               push_uop.rd  = rdf;
               push_uop.imm = imm6;
               case (f3)
                  3'd0: push_uop.code = OP_ADD;
                  3'd1: begin
                     if (rdf != REG_ZERO) begin
                        push_uop.code = OP_ADDW;
                     end
                  end
                  3'd2: begin
                     push_uop.code = OP_ADD;
                     push_uop.rs1  = REG_ZERO;
                  end
                  3'd3: begin
                     if (rdf == REG_SP) begin
                        if (t16sp != '0) begin
                           push_uop.code = OP_ADD;
                           push_uop.imm  = {{(XLEN-10){t16sp[9]}}, t16sp};
                        end
                     end else if (sh != '0) begin
                        push_uop.code = OP_ADD;
                        push_uop.rs1  = REG_ZERO;
                        push_uop.imm  = {imm6[XLEN-13:0], 12'h000};
                     end
                  end
                  3'd4: begin
                     push_uop.rs1 = rdp;
                     push_uop.rd  = rdp;
                     case (ins[11:10])
                        2'd0: begin
                           push_uop.code = OP_SRL;
                           push_uop.imm  = {{(XLEN-6){1'b0}}, sh};
                        end
                        2'd1: begin
                           push_uop.code = OP_SRA;
                           push_uop.imm  = {{(XLEN-6){1'b0}}, sh};
                        end
                        2'd2: push_uop.code = OP_AND;
                        default: begin
                           push_uop.rs2     = rs2p;
                           push_uop.use_rs2 = 1'b1;
                           case ({b12, ins[6:5]})
                              3'd0: push_uop.code = OP_SUB;
                              3'd1: push_uop.code = OP_XOR;
                              3'd2: push_uop.code = OP_OR;
                              3'd3: push_uop.code = OP_AND;
                              3'd4: push_uop.code = OP_SUBW;
                              3'd5: push_uop.code = OP_ADDW;
                              default: push_uop.code = OP_ILL;
                           endcase
                        end
                     endcase
                  end
                  3'd5: begin
                     push_uop.code = OP_JUMP;
                     push_uop.imm  = {{(XLEN-12){tj[11]}}, tj};
                  end
                  3'd6: begin
                     push_uop.code = OP_BEQZ;
                     push_uop.rs1  = rdp;
                     push_uop.imm  = {{(XLEN-9){tb[8]}}, tb};
                  end
                  default: begin
                     push_uop.code = OP_BNEZ;
                     push_uop.rs1  = rdp;
                     push_uop.imm  = {{(XLEN-9){tb[8]}}, tb};
                  end
               endcase
            end
            QUAD_2: begin
               push_uop.rs1 = rdf;
               push_uop.rd  = rdf;
               case (f3)
                  3'd0: begin
                     push_uop.code = OP_SLL;
                     push_uop.imm  = {{(XLEN-6){1'b0}}, sh};
                  end
                  3'd2: begin
                     if (rdf != REG_ZERO) begin
                        push_uop.code = OP_LOAD;
                        push_uop.rs1  = REG_SP;
                        push_uop.imm  = {{(XLEN-8){1'b0}}, tlwsp};
                     end
                  end
                  3'd3: begin
                     if (rdf != REG_ZERO) begin
                        push_uop.code = OP_LOAD;
                        push_uop.rs1  = REG_SP;
                        push_uop.wide = 1'b1;
                        push_uop.imm  = {{(XLEN-9){1'b0}}, tldsp};
                     end
                  end
                  3'd4: begin
                     if (rs2f == REG_ZERO) begin
                        if (rdf == REG_ZERO) begin
                           push_uop.code = b12 ? OP_BRK : OP_ILL;
                        end else if (b12) begin
                           push_uop.code = OP_JALR;
                           push_uop.rd   = REG_RA;
                        end else begin
                           push_uop.code = OP_JR;
                        end
                     end else begin
                        push_uop.code    = OP_ADD;
                        push_uop.rs2     = rs2f;
                        push_uop.use_rs2 = 1'b1;
                        if (!b12) begin
                           push_uop.rs1 = REG_ZERO;
                        end
                     end
                  end
                  3'd6: begin
                     push_uop.code = OP_STORE;
                     push_uop.rs1  = REG_SP;
                     push_uop.rs2  = rs2f;
                     push_uop.rd   = REG_ZERO;
                     push_uop.imm  = {{(XLEN-8){1'b0}}, tswsp};
                  end
                  3'd7: begin
                     push_uop.code = OP_STORE;
                     push_uop.rs1  = REG_SP;
                     push_uop.rs2  = rs2f;
                     push_uop.rd   = REG_ZERO;
                     push_uop.wide = 1'b1;
                     push_uop.imm  = {{(XLEN-9){1'b0}}, tsdsp};
                  end
                  default: push_uop.code = OP_ILL;
               endcase
            end
            default: push_uop.code = OP_ILL;
         endcase
      end
   end
endmodule

### design/rvce_queue.sv
// Short FIFO of classified items between the front and the back.
module rvce_queue import rvce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  uop_type push_uop,
   output logic    q_ready,
   input  logic    pop,
   output logic    q_valid,
   output uop_type q_uop
);
   uop_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign q_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_uop   = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + QUEUE_PTR_W'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + QUEUE_PTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= push_uop;
      end
   end
endmodule

### design/rvce_back.sv
// Back end: register file read, execute, pending access tracking and result register.
module rvce_back import rvce_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  uop_type   q_uop,
   output logic      pop,
   rvce_rsp_if.source rsp_bus
);
   uop_type              e_uop_ff;
   logic                 e_valid_ff, e_valid_in, e_adv;
   logic [REG_COUNT-1:0] reg_valid_ff;
   logic                 fwd1_ff, fwd2_ff, vld1_ff, vld2_ff;
   logic [XLEN-1:0]      fwd_val_ff, ram1, ram2, opa, opb, bop;
   logic                 pend_valid_ff, pend_valid_in;
   logic [REG_IDX_W-1:0] pend_dest_ff, pend_dest_in;
   logic [1:0]           pend_kind_ff, pend_kind_in;
   rsp_type              res, out_ff;
   logic                 out_valid_ff, out_valid_in;
   logic                 we, wb_en;
   logic [REG_IDX_W-1:0] wb_idx;
   logic [XLEN-1:0]      wb_val, sum, diff, pc2;
   logic [5:0]           shamt;

   assign e_adv = e_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign pop   = q_valid && (!e_valid_ff || e_adv);
   assign we    = e_adv && res.wb_valid;

   rvce_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
      .clock(clock), .we(we), .waddr(res.wb_index), .wdata(res.wb_value),
      .re(pop), .raddr(q_uop.rs1), .rdata(ram1)
   );

   rvce_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
      .clock(clock), .we(we), .waddr(res.wb_index), .wdata(res.wb_value),
      .re(pop), .raddr(q_uop.rs2), .rdata(ram2)
   );

   // A register never written reads as zero; a write in the read cycle is forwarded.
   assign opa   = fwd1_ff ? fwd_val_ff : (vld1_ff ? ram1 : '0);
   assign opb   = fwd2_ff ? fwd_val_ff : (vld2_ff ? ram2 : '0);
   assign bop   = e_uop_ff.use_rs2 ? opb : e_uop_ff.imm;
   assign sum   = opa + bop;
   assign diff  = opa - opb;
   assign pc2   = e_uop_ff.pc + XLEN'(2);
   assign shamt = e_uop_ff.imm[5:0];

   always_comb begin
      res           = '0;
      res.next_pc   = pc2;
      wb_en         = 1'b1;
      wb_idx        = e_uop_ff.rd;
      wb_val        = '0;
      pend_valid_in = 1'b0;
      pend_dest_in  = e_uop_ff.rd;
      pend_kind_in  = {e_uop_ff.code == OP_STORE, e_uop_ff.wide};
      case (e_uop_ff.code)
         OP_ADD:  wb_val = sum;
         OP_ADDW: wb_val = sext32(sum);
         OP_SUB:  wb_val = diff;
         OP_SUBW: wb_val = sext32(diff);
         OP_XOR:  wb_val = opa ^ opb;
         OP_OR:   wb_val = opa | opb;
         OP_AND:  wb_val = opa & bop;
         OP_SRL:  wb_val = opa >> shamt;
         OP_SRA:  wb_val = XLEN'($signed(opa) >>> shamt);
         OP_SLL:  wb_val = opa << shamt;
         OP_LOAD, OP_STORE: begin
            wb_en          = 1'b0;
            res.mem_valid  = 1'b1;
            res.mem_write  = (e_uop_ff.code == OP_STORE);
            res.mem_wide   = e_uop_ff.wide;
            res.mem_addr   = sum;
            res.store_data = (e_uop_ff.code == OP_STORE) ? opb : '0;
            pend_valid_in  = 1'b1;
         end
         OP_JUMP: begin
            wb_en       = 1'b0;
            res.next_pc = e_uop_ff.pc + e_uop_ff.imm;
         end
         OP_BEQZ, OP_BNEZ: begin
            wb_en = 1'b0;
            if ((e_uop_ff.code == OP_BEQZ) == (opa == '0)) begin
               res.next_pc = e_uop_ff.pc + e_uop_ff.imm;
            end
         end
         OP_JR: begin
            wb_en       = 1'b0;
            res.next_pc = {opa[XLEN-1:1], 1'b0};
         end
         OP_JALR: begin
            wb_val      = pc2;
            res.next_pc = {opa[XLEN-1:1], 1'b0};
         end
         OP_BRK: begin
            wb_en         = 1'b0;
            res.next_pc   = e_uop_ff.pc;
            res.exception = EXC_BREAKPOINT;
         end
         OP_RESP: begin
            wb_en       = 1'b0;
            res.next_pc = '0;
            wb_idx      = pend_dest_ff;
            if (pend_valid_ff) begin
               if (e_uop_ff.resp_fault) begin
                  res.exception = pend_kind_ff[1] ? EXC_STORE_FAULT : EXC_LOAD_FAULT;
               end else if (!pend_kind_ff[1]) begin
                  wb_en  = 1'b1;
                  wb_val = pend_kind_ff[0] ? e_uop_ff.resp_data
                                           : sext32(e_uop_ff.resp_data);
               end
            end
         end
         default: begin
            wb_en         = 1'b0;
            res.next_pc   = e_uop_ff.pc;
            res.exception = EXC_ILLEGAL;
         end
      endcase
      if (wb_en && wb_idx != REG_ZERO) begin
         res.wb_valid = 1'b1;
         res.wb_index = wb_idx;
         res.wb_value = wb_val;
      end
   end

   always_comb begin
      e_valid_in = e_valid_ff;
      if (pop) begin
         e_valid_in = 1'b1;
      end else if (e_adv) begin
         e_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (e_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         reg_valid_ff  <= '0;
         pend_valid_ff <= 1'b0;
         pend_dest_ff  <= '0;
         pend_kind_ff  <= '0;
      end else begin
         e_valid_ff   <= e_valid_in;
         out_valid_ff <= out_valid_in;
         if (we) begin
            reg_valid_ff[res.wb_index] <= 1'b1;
         end
         if (e_adv) begin
            pend_valid_ff <= pend_valid_in;
            if (e_uop_ff.code != OP_RESP) begin
               pend_dest_ff <= pend_dest_in;
               pend_kind_ff <= pend_kind_in;
            end
         end
      end
      if (pop) begin
         e_uop_ff   <= q_uop;
         fwd1_ff    <= we && (res.wb_index == q_uop.rs1);
         fwd2_ff    <= we && (res.wb_index == q_uop.rs2);
         vld1_ff    <= reg_valid_ff[q_uop.rs1];
         vld2_ff    <= reg_valid_ff[q_uop.rs2];
         fwd_val_ff <= res.wb_value;
      end
      if (e_adv) begin
         out_ff <= res;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_ff;
endmodule

### design/rv64c_compressed_execute_top.sv
// Top level of the RV64C compressed instruction execute block.
// Sustained rate is one item per clock while the result channel is ready; an
// item is accepted into a two-entry queue, is popped into the execute register
// while reading the register file, and then lands in the result register. The
// register file is two 32 x 64 memory copies (one per read port) with a
// write-through forward and per-register valid bits, so it reads as all zeros
// after reset with no clearing pass. A load or store result leaves one access
// pending; a later response item completes it with the loaded data or a fault,
// and any execute item abandons it.
module rv64c_compressed_execute_top import rvce_pkg::*; (
   input logic        clock,
   input logic        reset,
   rvce_req_if.sink   req_bus,
   rvce_rsp_if.source rsp_bus
);
   logic    push, q_ready, pop, q_valid;
   uop_type push_uop, q_uop;

   rvce_front u_front (
      .req_bus(req_bus), .q_ready(q_ready), .push(push), .push_uop(push_uop)
   );

   rvce_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_uop(push_uop),
      .q_ready(q_ready), .pop(pop), .q_valid(q_valid), .q_uop(q_uop)
   );

   rvce_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_uop(q_uop),
      .pop(pop), .rsp_bus(rsp_bus)
   );
endmodule

### design/rvce_checker.sv
// Port-level checks on the result channel of the execute block.
module rvce_checker import rvce_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_exc_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.exception != EXC_NONE |-> !rsp_data.mem_valid && !rsp_data.wb_valid)
      else $error("exception item also requests memory or writeback");

   a_no_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.wb_valid |-> rsp_data.wb_index != REG_ZERO)
      else $error("writeback to x0 reported");

   a_mem_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.mem_valid |->
         !rsp_data.mem_write && !rsp_data.mem_wide && rsp_data.mem_addr == '0 &&
         rsp_data.store_data == '0)
      else $error("memory fields set without a request");

   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind rv64c_compressed_execute_top rvce_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready), .rsp_data(rsp_bus.data)
);

### test/rv64c_compressed_execute_check.sv
// Checker for the RV64C execute block: predicts each result and compares it.
`timescale 1ns / 1ps
module rv64c_compressed_execute_check import rvce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   output int         fail_count,
   output int         outstanding
);
   localparam logic [1:0] KIND_LW = 2'd0;
   localparam logic [1:0] KIND_LD = 2'd1;
   localparam logic [1:0] KIND_SW = 2'd2;
   localparam logic [1:0] KIND_SD = 2'd3;

   logic [XLEN-1:0] arch_regs [REG_COUNT];
   logic            acc_open;
   logic [4:0]      acc_dest;
   logic [1:0]      acc_kind;
   rsp_type         expected_results [$];
   rsp_type         res;

   function automatic logic [XLEN-1:0] sign_ext(input logic [XLEN-1:0] v, input int bits);
      logic [XLEN-1:0] m;
      m = 64'd1 << (bits - 1);
      v = v & ((m << 1) - 1);
      return (v ^ m) - m;
   endfunction

   task automatic write_reg(input logic [4:0] i, input logic [XLEN-1:0] v);
      if (i != REG_ZERO) begin
         arch_regs[i] = v;
         res.wb_valid = 1'b1;
         res.wb_index = i;
         res.wb_value = v;
      end
   endtask

   task automatic start_access(input logic [XLEN-1:0] a, input logic [1:0] k,
                               input logic [4:0] d, input logic [XLEN-1:0] sd);
      res.mem_valid = 1'b1;
      res.mem_write = k[1];
      res.mem_wide = k[0];
      res.mem_addr = a;
      res.store_data = k[1] ? sd : '0;
      acc_open = 1'b1;
      acc_kind = k;
      acc_dest = d;
   endtask

   task automatic raise(input logic [XLEN-1:0] pc, input logic [2:0] code);
      res.next_pc = pc;
      res.exception = code;
   endtask

   task automatic run_instr(input logic [15:0] ins, input logic [XLEN-1:0] pc);
      logic [1:0] q;
      logic [2:0] f3;
      logic b12;
      logic [4:0] rdf, rs2f, rdp, rs2p;
      logic [5:0] sh;
      logic [XLEN-1:0] imm6, offw, offd, v, t;
      q = ins[1:0]; f3 = ins[15:13]; b12 = ins[12];
      rdf = ins[11:7]; rs2f = ins[6:2];
      rdp = {2'b01, ins[9:7]}; rs2p = {2'b01, ins[4:2]};
      sh = {b12, rs2f};
      imm6 = sign_ext(64'(sh), 6);
      offw = 64'({ins[5], ins[12:10], ins[6], 2'b00});
      offd = 64'({ins[6:5], ins[12:10], 3'b000});
      res.next_pc = pc + 2;
      if (q == QUAD_0) begin
         case (f3)
            3'd0: begin
               t = 64'({ins[10:7], ins[12:11], ins[5], ins[6], 2'b00});
               if (t == 0) raise(pc, EXC_ILLEGAL);
               else write_reg(rs2p, arch_regs[REG_SP] + t);
            end
            3'd2: start_access(arch_regs[rdp] + offw, KIND_LW, rs2p, '0);
            3'd3: start_access(arch_regs[rdp] + offd, KIND_LD, rs2p, '0);
            3'd6: start_access(arch_regs[rdp] + offw, KIND_SW, 5'd0, arch_regs[rs2p]);
            3'd7: start_access(arch_regs[rdp] + offd, KIND_SD, 5'd0, arch_regs[rs2p]);
            default: raise(pc, EXC_ILLEGAL);
         endcase
      end else if (q == QUAD_1) begin
         case (f3)
            3'd0: write_reg(rdf, arch_regs[rdf] + imm6);
            3'd1: begin
               if (rdf == REG_ZERO) raise(pc, EXC_ILLEGAL);
               else write_reg(rdf, sign_ext(arch_regs[rdf] + imm6, 32));
            end
            3'd2: write_reg(rdf, imm6);
            3'd3: begin
               if (rdf == REG_SP) begin
                  t = 64'({b12, ins[4:3], ins[5], ins[2], ins[6], 4'b0000});
                  if (t == 0) raise(pc, EXC_ILLEGAL);
                  else write_reg(REG_SP, arch_regs[REG_SP] + sign_ext(t, 10));
               end else if (sh == 0) raise(pc, EXC_ILLEGAL);
               else write_reg(rdf, imm6 << 12);
            end
            3'd4: begin
               v = arch_regs[rdp];
               case (ins[11:10])
                  2'd0: write_reg(rdp, v >> sh);
                  2'd1: write_reg(rdp, 64'($signed(v) >>> sh));
                  2'd2: write_reg(rdp, v & imm6);
                  default: begin
                     t = arch_regs[rs2p];
                     case ({b12, ins[6:5]})
                        3'd0: write_reg(rdp, v - t);
                        3'd1: write_reg(rdp, v ^ t);
                        3'd2: write_reg(rdp, v | t);
                        3'd3: write_reg(rdp, v & t);
                        3'd4: write_reg(rdp, sign_ext(v - t, 32));
                        3'd5: write_reg(rdp, sign_ext(v + t, 32));
                        default: raise(pc, EXC_ILLEGAL);
                     endcase
                  end
               endcase
            end
            3'd5: begin
               t = 64'({b12, ins[8], ins[10:9], ins[6], ins[7], ins[2], ins[11],
                        ins[5:3], 1'b0});
               res.next_pc = pc + sign_ext(t, 12);
            end
            default: begin
               t = 64'({b12, ins[6:5], ins[2], ins[11:10], ins[4:3], 1'b0});
               if ((f3 == 3'd6) == (arch_regs[rdp] == 0)) res.next_pc = pc + sign_ext(t, 9);
            end
         endcase
      end else if (q == QUAD_2) begin
         case (f3)
            3'd0: write_reg(rdf, arch_regs[rdf] << sh);
            3'd2: begin
               if (rdf == REG_ZERO) raise(pc, EXC_ILLEGAL);
               else start_access(arch_regs[REG_SP] + 64'({ins[3:2], b12, ins[6:4], 2'b00}),
                                 KIND_LW, rdf, '0);
            end
            3'd3: begin
               if (rdf == REG_ZERO) raise(pc, EXC_ILLEGAL);
               else start_access(arch_regs[REG_SP] + 64'({ins[4:2], b12, ins[6:5], 3'b000}),
                                 KIND_LD, rdf, '0);
            end
            3'd4: begin
               if (rs2f == 0) begin
                  if (rdf == REG_ZERO) raise(pc, b12 ? EXC_BREAKPOINT : EXC_ILLEGAL);
                  else begin
                     v = arch_regs[rdf] & ~64'd1;
                     if (b12) write_reg(REG_RA, pc + 2);
                     res.next_pc = v;
                  end
               end else if (!b12) write_reg(rdf, arch_regs[rs2f]);
               else write_reg(rdf, arch_regs[rdf] + arch_regs[rs2f]);
            end
            3'd6: start_access(arch_regs[REG_SP] + 64'({ins[8:7], ins[12:9], 2'b00}),
                               KIND_SW, 5'd0, arch_regs[rs2f]);
            3'd7: start_access(arch_regs[REG_SP] + 64'({ins[9:7], ins[12:10], 3'b000}),
                               KIND_SD, 5'd0, arch_regs[rs2f]);
            default: raise(pc, EXC_ILLEGAL);
         endcase
      end else raise(pc, EXC_ILLEGAL);
   endtask

   task automatic predict_item(input req_type r);
      res = '0;
      if (r.op) begin
         if (acc_open) begin
            if (r.resp_fault) res.exception = acc_kind[1] ? EXC_STORE_FAULT : EXC_LOAD_FAULT;
            else if (acc_kind == KIND_LW) write_reg(acc_dest, sign_ext(r.resp_data, 32));
            else if (acc_kind == KIND_LD) write_reg(acc_dest, r.resp_data);
            acc_open = 1'b0;
         end
      end else begin
         acc_open = 1'b0;
         run_instr(r.instr_bits, r.current_pc);
      end
      expected_results.push_back(res);
   endtask

   assign outstanding = expected_results.size();

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
         acc_open = 1'b0;
         acc_dest = '0;
         acc_kind = '0;
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else if (expected_results[0] !== rsp_data) begin
               $display("%0t: mismatch expected %h actual %h", $time,
                        expected_results[0], rsp_data);
               fail_count <= fail_count + 1;
               void'(expected_results.pop_front());
            end else void'(expected_results.pop_front());
         end
         if (req_valid && req_ready) predict_item(req_data);
      end
   end
endmodule

### test/rv64c_compressed_execute_top_test.sv
// Stimulus and verdict for the RV64C compressed execute block.
`timescale 1ns / 1ps
module rv64c_compressed_execute_top_test;
   import rvce_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   logic sink_hold;
   logic idle_free;

   rvce_req_if req_bus ();
   rvce_rsp_if rsp_bus ();

   rv64c_compressed_execute_top DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   rv64c_compressed_execute_check checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_bus.valid), .req_ready(req_bus.ready), .req_data(req_bus.data),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready), .rsp_data(rsp_bus.data),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("[rv64c_compressed_execute_top] ERROR");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off stretch requested by the sender.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (40) @(posedge clock);
            sink_hold = 1'b0;
         end
         rsp_bus.ready <= idle_free || ($urandom_range(99) >= 11);
      end
   end

   function automatic logic [15:0] pick_instr();
      logic [15:0] i;
      i = 16'($urandom);
      case ($urandom_range(9))
         0: i[1:0] = 2'b11;
         1, 2, 3: i[1:0] = QUAD_1;
         4, 5: i[1:0] = QUAD_2;
         default: i[1:0] = QUAD_0;
      endcase
      // Favor a nonzero stack pointer by steering toward a set-up form that loads sp.
      if ($urandom_range(9) == 0) i = {3'b010, i[12], 5'd2, i[6:2], 2'b01};
      return i;
   endfunction

   task automatic send(input logic op, input logic [15:0] ins, input logic [63:0] d,
                       input logic flt);
      req_bus.valid <= 1'b1;
      req_bus.data.op <= op;
      req_bus.data.instr_bits <= ins;
      req_bus.data.current_pc <= {$urandom, $urandom};
      req_bus.data.resp_data <= d;
      req_bus.data.resp_fault <= flt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!idle_free && $urandom_range(99) < 11) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [15:0] ins;
      ins = pick_instr();
      send(1'b0, ins, {$urandom, $urandom}, 1'b0);
      // Memory instructions are usually followed by their response.
      if ((ins[1:0] == QUAD_0 && ins[14]) || (ins[1:0] == QUAD_2 && ins[14:13] != 2'b00)
          || $urandom_range(9) == 0)
         if ($urandom_range(9) != 0)
            send(1'b1, 16'($urandom), {$urandom, $urandom}, $urandom_range(4) == 0);
   endtask

   initial begin
      logic [15:0] directed [$];
      directed = '{16'h0000, 16'h1001, 16'h4505, 16'h557d, 16'h6105, 16'h6505, 16'h0001,
                   16'h8c0d, 16'h9c2d, 16'h8109, 16'h8509, 16'h0506, 16'h9002, 16'h8082,
                   16'h8002, 16'h8502, 16'h9502, 16'h9582, 16'hc110, 16'he110, 16'h4110,
                   16'h6110, 16'hffff, 16'ha001, 16'h9c4d};
      reset = 1'b1;
      idle_free = 1'b0;
      sink_hold = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Response with nothing pending, then directed encodings each followed by a response.
      send(1'b1, 16'h0, 64'hffff_ffff_ffff_ffff, 1'b1);
      foreach (directed[k]) begin
         send(1'b0, directed[k], '0, 1'b0);
         send(1'b1, 16'h0, {$urandom, $urandom}, k[0]);
      end
      for (int n = 0; n < 700; n++) begin
         if (n == 200) sink_hold = 1'b1;
         if (n == 400) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
         end
         idle_free = (n >= 500 && n < 650);
         send_random();
      end
      req_bus.valid <= 1'b0;
      idle_free = 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("[rv64c_compressed_execute_top] OK");
      else
         $display("[rv64c_compressed_execute_top] ERROR");
      $finish;
   end
endmodule

### files.f
design/rvce_pkg.sv
design/rvce_req_if.sv
design/rvce_rsp_if.sv
design/rvce_ram.sv
design/rvce_front.sv
design/rvce_queue.sv
design/rvce_back.sv
design/rv64c_compressed_execute_top.sv
design/rvce_checker.sv
test/rv64c_compressed_execute_check.sv
test/rv64c_compressed_execute_top_test.sv
